// ===== hdl/bcb_pkg.sv =====
// ----------------------------------------------------------------------------
// bcb_pkg
// Types and codes shared by the half-duplex bus UART with collision backoff.
// ----------------------------------------------------------------------------
package bcb_pkg;

  // Internal bus mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_RX   = 5'b00010,
    MODE_TX   = 5'b00100,
    MODE_COLL = 5'b01000,
    MODE_BACK = 5'b10000
  } mode_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_SEND  = 2'd3
  } op_e;

  // send_status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_STARTED   = 3'd1;
  localparam logic [2:0] ST_CARRIER   = 3'd2;
  localparam logic [2:0] ST_PRIO      = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;
  localparam logic [2:0] ST_COLLISION = 3'd6;

  // timer_cmd codes
  localparam logic [2:0] TCMD_KEEP     = 3'd0;
  localparam logic [2:0] TCMD_RX_START = 3'd1;
  localparam logic [2:0] TCMD_RX_BIT   = 3'd2;
  localparam logic [2:0] TCMD_TX_BIT   = 3'd3;
  localparam logic [2:0] TCMD_STOP     = 3'd4;

  // bus_mode codes as seen on the port
  localparam logic [2:0] BUS_IDLE = 3'd0;
  localparam logic [2:0] BUS_RX   = 3'd1;
  localparam logic [2:0] BUS_TX   = 3'd2;
  localparam logic [2:0] BUS_COLL = 3'd3;
  localparam logic [2:0] BUS_BACK = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CARRIER   = 2'd0;
  localparam logic [1:0] CFG_COLLISION = 2'd1;
  localparam logic [1:0] CFG_BACKOFF   = 2'd2;

  localparam logic [7:0] CARRIER_RST   = 8'd20;
  localparam logic [7:0] COLLISION_RST = 8'd15;
  localparam logic [7:0] BACKOFF_RST   = 8'd40;

  localparam logic [7:0] CHECK_SEED = 8'hFF;
  localparam logic [7:0] FRAME_BITS = 8'd9;  // start + 8 data bits

  typedef struct packed {
    logic       data_we;
    logic [7:0] data_addr;
    logic [7:0] data;
    logic       ck_we;
    logic [7:0] ck_val;
  } store_wr_t;

  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_addr;
  } store_rd_t;

  typedef struct packed {
    logic       tx_level;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       framing_error;
    logic [2:0] send_status;
    logic [2:0] timer_cmd;
    logic [2:0] bus_mode;
  } result_t;

endpackage

// ===== hdl/bus_uart_collision_backoff.sv =====
// ----------------------------------------------------------------------------
// bus_uart_collision_backoff
// Bit-timed half-duplex bus UART with collision jamming and priority backoff.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  cfg     | cfg_we_i                   | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_stall_o    | operation, tx_byte, last_byte, rx_level,
//          |                            | collision_seen, prio_delay
//  out     | out_valid_o / out_stall_i  | tx_level, rx_valid, rx_data,
//          |                            | framing_error, send_status, timer_cmd,
//          |                            | bus_mode
//
// One item is taken per cycle while in_stall_o is low; its result is registered in bcb_out_buf.
// The rate is set by the single state update path in bcb_core plus the one
// write port of the packet memory (the checksum byte is kept in a register).
// A store reload of the transmit shift register is read on the accepting edge
// and consumed from the read register by the following item.
// in_stall_o rises only when both the result register and the skid stage hold
// items; reset clears all control state, the packet memory stays undefined.
// ----------------------------------------------------------------------------
module bus_uart_collision_backoff #(
  parameter int PACKET_BYTES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] tx_byte_i,
  input  logic       last_byte_i,
  input  logic       rx_level_i,
  input  logic       collision_seen_i,
  input  logic [7:0] prio_delay_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_level_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_data_o,
  output logic       framing_error_o,
  output logic [2:0] send_status_o,
  output logic [2:0] timer_cmd_o,
  output logic [2:0] bus_mode_o
);

  logic [7:0] carrier_q;
  logic [7:0] collision_q;
  logic [7:0] backoff_q;

  logic               in_fire;
  logic               buf_full;
  bcb_pkg::store_wr_t st_wr;
  bcb_pkg::store_rd_t st_rd;
  logic [7:0]         st_rd_data;
  logic [7:0]         pkt_len;
  bcb_pkg::result_t   core_res;
  bcb_pkg::result_t   out_res;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q   <= bcb_pkg::CARRIER_RST;
      collision_q <= bcb_pkg::COLLISION_RST;
      backoff_q   <= bcb_pkg::BACKOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bcb_pkg::CFG_CARRIER:   carrier_q   <= cfg_data_i;
        bcb_pkg::CFG_COLLISION: collision_q <= cfg_data_i;
        bcb_pkg::CFG_BACKOFF:   backoff_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  bcb_core #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (in_fire),
    .operation_i      (operation_i),
    .tx_byte_i        (tx_byte_i),
    .last_byte_i      (last_byte_i),
    .rx_level_i       (rx_level_i),
    .collision_seen_i (collision_seen_i),
    .prio_delay_i     (prio_delay_i),
    .carrier_ticks_i  (carrier_q),
    .collision_ticks_i(collision_q),
    .backoff_max_i    (backoff_q),
    .rd_data_i        (st_rd_data),
    .wr_o             (st_wr),
    .rd_o             (st_rd),
    .len_o            (pkt_len),
    .result_o         (core_res)
  );

  bcb_pkt_store #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (st_wr),
    .rd_i     (st_rd),
    .pkt_len_i(pkt_len),
    .rd_data_o(st_rd_data)
  );

  bcb_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_fire),
    .res_i      (core_res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_res)
  );

  assign tx_level_o      = out_res.tx_level;
  assign rx_valid_o      = out_res.rx_valid;
  assign rx_data_o       = out_res.rx_data;
  assign framing_error_o = out_res.framing_error;
  assign send_status_o   = out_res.send_status;
  assign timer_cmd_o     = out_res.timer_cmd;
  assign bus_mode_o      = out_res.bus_mode;

`ifndef ASSERT_OFF
  // the line is only pulled low while sending or jamming
  a_low_drive_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_level_o) |->
      (bus_mode_o == bcb_pkg::BUS_TX || bus_mode_o == bcb_pkg::BUS_COLL))
    else $error("line driven low outside transmit or collision");
`endif

endmodule

// ===== hdl/bcb_pkt_store.sv =====
// ----------------------------------------------------------------------------
// bcb_pkt_store
// Packet byte memory with a separate checksum slot and registered read.
// ----------------------------------------------------------------------------
module bcb_pkt_store #(
  parameter int PACKET_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcb_pkg::store_wr_t wr_i,
  input  bcb_pkg::store_rd_t rd_i,
  input  logic [7:0]         pkt_len_i,
  output logic [7:0]         rd_data_o
);

  localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic [7:0] mem_q [PACKET_BYTES];
  logic [7:0] ck_q;
  logic       ck_ok_q;
  logic [7:0] rd_data_q;
  logic [7:0] ck_slot;
  logic       len_nz;
  logic       rd_hits_ck;

  // Checksum lives in a register; it sits at index pkt_len-1 until a data
  // byte of a newer packet overwrites that slot.
  assign ck_slot    = pkt_len_i - 8'd1;
  assign len_nz     = (pkt_len_i != 8'd0);
  assign rd_hits_ck = ck_ok_q && len_nz && (rd_i.rd_addr == ck_slot);

  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      mem_q[wr_i.data_addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ck_we) begin
      ck_q <= wr_i.ck_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ck_ok_q <= 1'b0;
    end else if (wr_i.ck_we) begin
      ck_ok_q <= 1'b1;
    end else if (wr_i.data_we && len_nz && (wr_i.data_addr == ck_slot)) begin
      ck_ok_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.rd_en) begin
      rd_data_q <= rd_hits_ck ? ck_q : mem_q[rd_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bcb_core.sv =====
// ----------------------------------------------------------------------------
// bcb_core
// Bus mode state, bit timing and packet bookkeeping; one item per cycle when fire_i is set.
// ----------------------------------------------------------------------------
module bcb_core #(
  parameter int PACKET_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               last_byte_i,
  input  logic               rx_level_i,
  input  logic               collision_seen_i,
  input  logic [7:0]         prio_delay_i,
  input  logic [7:0]         carrier_ticks_i,
  input  logic [7:0]         collision_ticks_i,
  input  logic [7:0]         backoff_max_i,
  input  logic [7:0]         rd_data_i,
  output bcb_pkg::store_wr_t wr_o,
  output bcb_pkg::store_rd_t rd_o,
  output logic [7:0]         len_o,
  output bcb_pkg::result_t   result_o
);

  localparam logic [8:0] PB = 9'(PACKET_BYTES);

  bcb_pkg::mode_e mode_q, mode_v;
  logic [7:0] tick_q, tick_v;
  logic [7:0] shift_q, shift_v, shift_cur;
  logic       pend_q, pend_v;
  logic [7:0] idx_q, idx_v;
  logic [7:0] len_q, len_v;
  logic [7:0] lp_q, lp_v;
  logic [7:0] chk_q, chk_v;
  logic       drive_q, drive_v;
  logic [7:0] prio_v;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       ferr;
  logic [2:0] status;
  logic [2:0] tcmd;
  logic [2:0] bus_code;

  // shift register reloads from the store come through its read register, used by the next accepted item
  assign shift_cur = pend_q ? rd_data_i : shift_q;

  always_comb begin
    mode_v   = mode_q;
    tick_v   = tick_q;
    shift_v  = shift_cur;
    pend_v   = 1'b0;
    idx_v    = idx_q;
    len_v    = len_q;
    lp_v     = lp_q;
    chk_v    = chk_q;
    drive_v  = drive_q;
    prio_v   = prio_delay_i;
    wr_o     = '0;
    rd_o     = '0;
    rx_valid = 1'b0;
    rx_data  = 8'd0;
    ferr     = 1'b0;
    status   = bcb_pkg::ST_NONE;
    tcmd     = bcb_pkg::TCMD_KEEP;

    case (bcb_pkg::op_e'(operation_i))
      bcb_pkg::OP_LOAD: begin
        if (mode_v != bcb_pkg::MODE_TX) begin
          if (({1'b0, lp_v} + 9'd1) < PB) begin
            wr_o.data_we   = 1'b1;
            wr_o.data_addr = lp_v;
            wr_o.data      = tx_byte_i;
            chk_v          = chk_v ^ tx_byte_i;
            lp_v           = lp_v + 8'd1;
          end
          if (last_byte_i) begin
            wr_o.ck_we  = 1'b1;
            wr_o.ck_val = chk_v;
            len_v       = lp_v + 8'd1;
            lp_v        = 8'd0;
            chk_v       = bcb_pkg::CHECK_SEED;
          end
        end
      end
      bcb_pkg::OP_START: begin
        if (mode_v == bcb_pkg::MODE_IDLE || mode_v == bcb_pkg::MODE_BACK) begin
          mode_v = bcb_pkg::MODE_RX;
          tick_v = 8'd0;
          tcmd   = bcb_pkg::TCMD_RX_START;
        end
      end
      bcb_pkg::OP_TICK: begin
        if (mode_v != bcb_pkg::MODE_IDLE) begin
          if (tick_v == 8'd0 && mode_v == bcb_pkg::MODE_RX) begin
            tcmd = bcb_pkg::TCMD_RX_BIT;
          end
          tick_v = tick_v + 8'd1;
          if (mode_v == bcb_pkg::MODE_RX) begin
            if (tick_v < bcb_pkg::FRAME_BITS) begin
              shift_v = {rx_level_i, shift_v[7:1]};
            end else begin
              if (!rx_level_i) begin
                ferr = 1'b1;
              end else begin
                rx_valid = 1'b1;
                rx_data  = shift_v;
              end
              tick_v = 8'd0;
              mode_v = bcb_pkg::MODE_BACK;
            end
          end
          if (mode_v == bcb_pkg::MODE_TX) begin
            if (collision_seen_i) begin
              tick_v = 8'd0;
              mode_v = bcb_pkg::MODE_COLL;
              status = bcb_pkg::ST_COLLISION;
            end else if (tick_v < bcb_pkg::FRAME_BITS) begin
              drive_v = shift_v[0];
              shift_v = {1'b0, shift_v[7:1]};
            end else if (tick_v == bcb_pkg::FRAME_BITS) begin
              drive_v = 1'b1;
            end else begin
              idx_v = idx_v + 8'd1;
              if (idx_v < len_v) begin
                tick_v     = 8'd0;
                rd_o.rd_en = 1'b1;
                rd_o.rd_addr = idx_v;
                pend_v     = 1'b1;
                drive_v    = 1'b0;
                tcmd       = bcb_pkg::TCMD_TX_BIT;
              end else begin
                status = bcb_pkg::ST_DONE;
                tick_v = 8'd0;
                mode_v = bcb_pkg::MODE_BACK;
              end
            end
          end
          if (mode_v == bcb_pkg::MODE_COLL) begin
            if (tick_v == 8'd0) begin
              drive_v = 1'b0;
            end else if (tick_v >= collision_ticks_i) begin
              drive_v = 1'b1;
              tick_v  = 8'd0;
              mode_v  = bcb_pkg::MODE_BACK;
            end
          end
          if (mode_v == bcb_pkg::MODE_BACK) begin
            if (tick_v != 8'd0 && tick_v >= backoff_max_i) begin
              mode_v = bcb_pkg::MODE_IDLE;
              tcmd   = bcb_pkg::TCMD_STOP;
            end
          end
        end
      end
      bcb_pkg::OP_SEND: begin
        if (prio_v > backoff_max_i) begin
          prio_v = backoff_max_i;
        end
        if (mode_v == bcb_pkg::MODE_BACK && tick_v >= prio_v) begin
          mode_v = bcb_pkg::MODE_IDLE;
          tcmd   = bcb_pkg::TCMD_STOP;
        end
        if (mode_v == bcb_pkg::MODE_BACK) begin
          status = (tick_v < carrier_ticks_i) ? bcb_pkg::ST_CARRIER : bcb_pkg::ST_PRIO;
        end else if (mode_v != bcb_pkg::MODE_IDLE) begin
          status = bcb_pkg::ST_BUSY;
        end else if (len_v == 8'd0) begin
          status = bcb_pkg::ST_NONE;
        end else if (!rx_level_i) begin
          status = bcb_pkg::ST_BUSY;  // bus held low by another node
        end else begin
          drive_v      = 1'b0;
          idx_v        = 8'd0;
          rd_o.rd_en   = 1'b1;
          rd_o.rd_addr = 8'd0;
          pend_v       = 1'b1;
          mode_v       = bcb_pkg::MODE_TX;
          tick_v       = 8'd0;
          status       = bcb_pkg::ST_STARTED;
          tcmd         = bcb_pkg::TCMD_TX_BIT;
        end
      end
      default: begin
      end
    endcase

    // store accesses only count for an accepted item
    if (!fire_i) begin
      wr_o = '0;
      rd_o = '0;
    end
  end

  always_comb begin
    case (mode_v)
      bcb_pkg::MODE_IDLE: bus_code = bcb_pkg::BUS_IDLE;
      bcb_pkg::MODE_RX:   bus_code = bcb_pkg::BUS_RX;
      bcb_pkg::MODE_TX:   bus_code = bcb_pkg::BUS_TX;
      bcb_pkg::MODE_COLL: bus_code = bcb_pkg::BUS_COLL;
      bcb_pkg::MODE_BACK: bus_code = bcb_pkg::BUS_BACK;
      default:            bus_code = bcb_pkg::BUS_IDLE;
    endcase
  end

  assign result_o = '{
    tx_level:      drive_v,
    rx_valid:      rx_valid,
    rx_data:       rx_data,
    framing_error: ferr,
    send_status:   status,
    timer_cmd:     tcmd,
    bus_mode:      bus_code
  };

  // current packet length, locates the checksum slot in the store
  assign len_o = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bcb_pkg::MODE_IDLE;
      tick_q  <= 8'd0;
      shift_q <= 8'd0;
      pend_q  <= 1'b0;
      idx_q   <= 8'd0;
      len_q   <= 8'd0;
      lp_q    <= 8'd0;
      chk_q   <= bcb_pkg::CHECK_SEED;
      drive_q <= 1'b1;
    end else if (fire_i) begin
      mode_q  <= mode_v;
      tick_q  <= tick_v;
      shift_q <= shift_v;
      pend_q  <= pend_v;
      idx_q   <= idx_v;
      len_q   <= len_v;
      lp_q    <= lp_v;
      chk_q   <= chk_v;
      drive_q <= drive_v;
    end
  end

`ifndef ASSERT_OFF
  // a store reload is only ever pending for a packet being sent
  a_pend_in_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> (mode_q == bcb_pkg::MODE_TX))
    else $error("shift reload pending outside transmit");
`endif

endmodule

// ===== hdl/bcb_out_buf.sv =====
// ----------------------------------------------------------------------------
// bcb_out_buf
// Result register with a skid stage; input acceptance waits on out only once the skid is full.
// ----------------------------------------------------------------------------
module bcb_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bcb_pkg::result_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bcb_pkg::result_t out_o
);

  logic             out_valid_q;
  bcb_pkg::result_t out_q;
  logic             skid_valid_q;
  bcb_pkg::result_t skid_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output register is empty");

  a_push_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("item pushed against a stalled output was lost");
`endif

endmodule

// ===== verif/tb_bus_uart_collision_backoff.sv =====
// ----------------------------------------------------------------------------
// tb_bus_uart_collision_backoff
// Self-checking bench for the half-duplex bus UART with collision backoff.
// A cycle-level predictor tracks mode, tick counters, shift register, packet
// store and checksum. Every accepted item is predicted and every result is
// compared field by field. Stimulus covers directed corner cases, framed
// receives, packet loads, sends with collisions, backoff send tries, a
// completely full packet store and several register settings. Both sides
// insert random gaps, and the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
class bus_uart_scoreboard;
  localparam int STORE_DEPTH = 128;

  logic [7:0] carrier_ticks, collision_ticks, backoff_max;
  logic [2:0] mode;
  logic [7:0] ticks, shift, send_idx, pkt_len, load_ptr, run_check;
  logic [7:0] store [STORE_DEPTH];
  logic       line;
  bcb_pkg::result_t pending_results[$];
  int         errors, n_checked, n_rx, n_ferr, n_done, n_coll;

  function new();
    carrier_ticks   = bcb_pkg::CARRIER_RST;
    collision_ticks = bcb_pkg::COLLISION_RST;
    backoff_max     = bcb_pkg::BACKOFF_RST;
    mode      = bcb_pkg::BUS_IDLE;
    ticks     = '0;
    shift     = '0;
    send_idx  = '0;
    pkt_len   = '0;
    load_ptr  = '0;
    run_check = bcb_pkg::CHECK_SEED;
    line      = 1'b1;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] v);
    case (idx)
      bcb_pkg::CFG_CARRIER:   carrier_ticks = v;
      bcb_pkg::CFG_COLLISION: collision_ticks = v;
      bcb_pkg::CFG_BACKOFF:   backoff_max = v;
      default: ;
    endcase
  endfunction

  function logic [7:0] read_store(logic [7:0] idx);
    return (idx < STORE_DEPTH) ? store[idx] : 8'h00;
  endfunction

  // Advance the bus state by one item and queue the result it produces.
  function void note_item(bcb_pkg::op_e op, logic [7:0] data_b, logic last_b,
                          logic rx, logic coll, logic [7:0] prio);
    bcb_pkg::result_t r;
    logic [7:0]       lim;
    bit               shifting;
    r = '0;
    shifting = 1'b0;
    case (op)
      bcb_pkg::OP_LOAD: begin
        if (mode != bcb_pkg::BUS_TX) begin
          // last slot is reserved for the checksum
          if (int'(load_ptr) + 1 < STORE_DEPTH) begin
            store[load_ptr] = data_b;
            run_check ^= data_b;
            load_ptr++;
          end
          if (last_b) begin
            if (load_ptr < STORE_DEPTH) store[load_ptr] = run_check;
            pkt_len   = load_ptr + 8'd1;
            load_ptr  = '0;
            run_check = bcb_pkg::CHECK_SEED;
          end
        end
      end
      bcb_pkg::OP_START: begin
        if (mode == bcb_pkg::BUS_IDLE || mode == bcb_pkg::BUS_BACK) begin
          mode  = bcb_pkg::BUS_RX;
          ticks = '0;
          r.timer_cmd = bcb_pkg::TCMD_RX_START;
        end
      end
      bcb_pkg::OP_TICK: begin
        if (mode != bcb_pkg::BUS_IDLE) begin
          if (ticks == 0 && mode == bcb_pkg::BUS_RX) r.timer_cmd = bcb_pkg::TCMD_RX_BIT;
          ticks++;
          if (mode == bcb_pkg::BUS_RX) begin
            if (ticks < bcb_pkg::FRAME_BITS) begin
              shift = {rx, shift[7:1]};
              shifting = 1'b1;
            end else begin
              if (!rx) r.framing_error = 1'b1;
              else begin
                r.rx_valid = 1'b1;
                r.rx_data  = shift;
              end
              ticks = '0;
              mode  = bcb_pkg::BUS_BACK;
            end
          end
          if (!shifting) begin
            if (mode == bcb_pkg::BUS_TX) begin
              if (coll) begin
                ticks = '0;
                mode  = bcb_pkg::BUS_COLL;
                r.send_status = bcb_pkg::ST_COLLISION;
              end else if (ticks < bcb_pkg::FRAME_BITS) begin
                line  = shift[0];
                shift = shift >> 1;
              end else if (ticks == bcb_pkg::FRAME_BITS) begin
                line = 1'b1;
              end else begin
                send_idx++;
                if (send_idx < pkt_len) begin
                  ticks = '0;
                  shift = read_store(send_idx);
                  line  = 1'b0;
                  r.timer_cmd = bcb_pkg::TCMD_TX_BIT;
                end else begin
                  r.send_status = bcb_pkg::ST_DONE;
                  ticks = '0;
                  mode  = bcb_pkg::BUS_BACK;
                end
              end
            end
            if (mode == bcb_pkg::BUS_COLL) begin
              if (ticks == 0) line = 1'b0;
              else if (ticks >= collision_ticks) begin
                line  = 1'b1;
                ticks = '0;
                mode  = bcb_pkg::BUS_BACK;
              end
            end
            if (mode == bcb_pkg::BUS_BACK) begin
              if (ticks != 0 && ticks >= backoff_max) begin
                mode = bcb_pkg::BUS_IDLE;
                r.timer_cmd = bcb_pkg::TCMD_STOP;
              end
            end
          end
        end
      end
      default: begin
        lim = (prio > backoff_max) ? backoff_max : prio;
        if (mode == bcb_pkg::BUS_BACK && ticks >= lim) begin
          mode = bcb_pkg::BUS_IDLE;
          r.timer_cmd = bcb_pkg::TCMD_STOP;
        end
        if (mode == bcb_pkg::BUS_BACK) begin
          r.send_status = (ticks < carrier_ticks) ? bcb_pkg::ST_CARRIER
                                                  : bcb_pkg::ST_PRIO;
        end else if (mode != bcb_pkg::BUS_IDLE) begin
          r.send_status = bcb_pkg::ST_BUSY;
        end else if (pkt_len == 0) begin
          r.send_status = bcb_pkg::ST_NONE;
        end else if (!rx) begin
          r.send_status = bcb_pkg::ST_BUSY;
        end else begin
          line     = 1'b0;
          send_idx = '0;
          shift    = read_store(8'd0);
          mode     = bcb_pkg::BUS_TX;
          ticks    = '0;
          r.send_status = bcb_pkg::ST_STARTED;
          r.timer_cmd   = bcb_pkg::TCMD_TX_BIT;
        end
      end
    endcase
    r.tx_level = line;
    r.bus_mode = mode;
    if (r.rx_valid) n_rx++;
    if (r.framing_error) n_ferr++;
    if (r.send_status == bcb_pkg::ST_DONE) n_done++;
    if (r.send_status == bcb_pkg::ST_COLLISION) n_coll++;
    pending_results.push_back(r);
  endfunction

  function void cmp_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endfunction

  function void check_result(bcb_pkg::result_t got);
    bcb_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result arrived with no pending expectation");
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    n_checked++;
    cmp_field("tx_level", exp_r.tx_level, got.tx_level);
    cmp_field("rx_valid", exp_r.rx_valid, got.rx_valid);
    cmp_field("rx_data", exp_r.rx_data, got.rx_data);
    cmp_field("framing_error", exp_r.framing_error, got.framing_error);
    cmp_field("send_status", exp_r.send_status, got.send_status);
    cmp_field("timer_cmd", exp_r.timer_cmd, got.timer_cmd);
    cmp_field("bus_mode", exp_r.bus_mode, got.bus_mode);
  endfunction
endclass

module tb_bus_uart_collision_backoff;

  // quiet cycles (nothing accepted anywhere) tolerated before giving up;
  // worst legal quiet stretch is the hold-off plus a long sender gap
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] operation_i;
  logic [7:0] tx_byte_i;
  logic       last_byte_i;
  logic       rx_level_i;
  logic       collision_seen_i;
  logic [7:0] prio_delay_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       tx_level_o;
  logic       rx_valid_o;
  logic [7:0] rx_data_o;
  logic       framing_error_o;
  logic [2:0] send_status_o;
  logic [2:0] timer_cmd_o;
  logic [2:0] bus_mode_o;

  bus_uart_scoreboard sb;

  int items_sent;
  int quiet_cycles;
  int gap_style;      // 0 no gaps, 1 light, 2 heavy
  int stall_style;    // same scale for the result side
  int hold_requests;  // bumped by the stimulus to ask for a long hold-off
  int hold_served;
  int stall_left;

  bus_uart_collision_backoff DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .tx_byte_i       (tx_byte_i),
    .last_byte_i     (last_byte_i),
    .rx_level_i      (rx_level_i),
    .collision_seen_i(collision_seen_i),
    .prio_delay_i    (prio_delay_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_level_o      (tx_level_o),
    .rx_valid_o      (rx_valid_o),
    .rx_data_o       (rx_data_o),
    .framing_error_o (framing_error_o),
    .send_status_o   (send_status_o),
    .timer_cmd_o     (timer_cmd_o),
    .bus_mode_o      (bus_mode_o)
  );

  always #1 clk_i = ~clk_i;

  // Gap/stall length: drawn from a short, a middle and a long range, the long one rarely.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 25);
  endfunction

  function automatic int pick_gap();
    if (gap_style == 0) return 0;
    if ($urandom_range(0, 99) < ((gap_style == 1) ? 70 : 40)) return 0;
    return pick_len();
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Send try delay: half the time near the ticks already spent in backoff,
  // so both the early exit and the wait branch get hit.
  function automatic logic [7:0] pick_prio();
    if (rbit()) return 8'($urandom_range(0, int'(sb.ticks) + 3));
    return 8'($urandom);
  endfunction

  // Result side: random stalls, plus the long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      stall_left  = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (stall_style != 0 &&
                 $urandom_range(0, 99) < ((stall_style == 1) ? 15 : 45)) begin
      stall_left = pick_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // prediction.
  always @(posedge clk_i) begin : result_monitor
    bcb_pkg::result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.tx_level      = tx_level_o;
      got.rx_valid      = rx_valid_o;
      got.rx_data       = rx_data_o;
      got.framing_error = framing_error_o;
      got.send_status   = send_status_o;
      got.timer_cmd     = timer_cmd_o;
      got.bus_mode      = bus_mode_o;
      sb.check_result(got);
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One item: optional gap, then hold valid and payload until accepted.
  // The prediction is made here, right at the accepting edge, so the
  // stimulus code always sees up-to-date predicted state.
  task automatic send_item(input bcb_pkg::op_e op, input logic [7:0] data_b,
                           input logic last_b, input logic rx, input logic coll,
                           input logic [7:0] prio);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    tx_byte_i        <= data_b;
    last_byte_i      <= last_b;
    rx_level_i       <= rx;
    collision_seen_i <= coll;
    prio_delay_i     <= prio;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, data_b, last_b, rx, coll, prio);
    items_sent++;
  endtask

  // Unused fields of each operation are randomized too.
  task automatic load_byte(input logic [7:0] b, input logic last_b);
    send_item(bcb_pkg::OP_LOAD, b, last_b, rbit(), rbit(), 8'($urandom));
  endtask

  task automatic start_edge(input logic rx);
    send_item(bcb_pkg::OP_START, 8'($urandom), rbit(), rx, rbit(), 8'($urandom));
  endtask

  task automatic bit_tick(input logic rx, input logic coll);
    send_item(bcb_pkg::OP_TICK, 8'($urandom), rbit(), rx, coll, 8'($urandom));
  endtask

  task automatic send_try(input logic rx, input logic [7:0] prio);
    send_item(bcb_pkg::OP_SEND, 8'($urandom), rbit(), rx, rbit(), prio);
  endtask

  // Valid must drop before anything that waits without offering an item.
  task automatic release_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Start edge, eight data bits LSB first, stop bit.
  task automatic rx_frame(input logic [7:0] d, input logic stop);
    int i;
    start_edge(rbit());
    for (i = 0; i < 8; i++) bit_tick(d[i], rbit());
    bit_tick(stop, rbit());
  endtask

  task automatic load_packet(input int n);
    int i;
    for (i = 0; i < n; i++) load_byte(8'($urandom), i == n - 1);
  endtask

  // Send try, then bit ticks until the send ends; stray loads, send tries and
  // start edges are mixed in and must be ignored or reported busy.
  task automatic transmit(input int coll_permille);
    int guard;
    int r;
    guard = 0;
    send_try($urandom_range(0, 9) != 0, pick_prio());
    while ((sb.mode == bcb_pkg::BUS_TX || sb.mode == bcb_pkg::BUS_COLL) &&
           guard < 3000) begin
      guard++;
      r = $urandom_range(0, 99);
      if (r < 4) load_byte(8'($urandom), rbit());
      else if (r < 7) send_try(rbit(), pick_prio());
      else if (r < 10) start_edge(rbit());
      else bit_tick(rbit(), $urandom_range(0, 999) < coll_permille);
    end
  endtask

  // Spends a bounded number of items in backoff; long backoff settings are
  // left to the following stimulus.
  task automatic backoff_wait();
    int guard;
    int r;
    guard = 0;
    while (sb.mode == bcb_pkg::BUS_BACK && guard < 60) begin
      guard++;
      r = $urandom_range(0, 99);
      if (r < 12) send_try($urandom_range(0, 4) != 0, pick_prio());
      else if (r < 15) start_edge(rbit());
      else bit_tick(rbit(), rbit());
    end
  endtask

  task automatic settle_idle();
    int guard;
    guard = 0;
    while (sb.mode != bcb_pkg::BUS_IDLE && guard < 5000) begin
      guard++;
      bit_tick(rbit(), 1'b0);
    end
  endtask

  task automatic directed_checks();
    send_try(1'b1, 8'd255);     // no packet loaded yet: status none
    bit_tick(1'b1, 1'b1);       // tick while idle does nothing
    load_byte(8'hFF, 1'b0);
    load_byte(8'h00, 1'b1);     // two data bytes plus checksum
    send_try(1'b0, 8'd0);       // line low in idle: busy
    start_edge(1'b1);
    rx_frame(8'h00, 1'b0);      // its start edge is ignored; stop low: framing error
    send_try(1'b1, 8'd255);     // backoff, delay clipped: carrier wait
    rx_frame(8'hFF, 1'b1);      // start edge accepted from backoff, good byte
    send_try(1'b1, 8'd0);       // zero delay: backoff ends, send starts
    bit_tick(1'b1, 1'b0);
    load_byte(8'h5A, 1'b1);     // load while sending is dropped
    send_try(1'b1, 8'd0);       // busy while sending
    bit_tick(1'b0, 1'b1);       // collision on the line
  endtask

  task automatic run_phase(input logic [7:0] car, input logic [7:0] col,
                           input logic [7:0] bk, input int n_items,
                           input bit with_hold);
    int target;
    int r;
    release_bus();
    drain();
    set_reg(bcb_pkg::CFG_CARRIER, car);
    set_reg(bcb_pkg::CFG_COLLISION, col);
    set_reg(bcb_pkg::CFG_BACKOFF, bk);
    if (with_hold) begin
      // receiver holds off while the sender keeps offering back to back
      gap_style = 0;
      hold_requests++;
      load_packet(8);
      repeat (12) bit_tick(rbit(), rbit());
    end
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        gap_style   = $urandom_range(0, 2);
        stall_style = $urandom_range(0, 2);
      end
      r = $urandom_range(0, 99);
      if (r < 20) rx_frame(8'($urandom), $urandom_range(0, 9) != 0);
      else if (r < 38) begin
        load_packet(($urandom_range(0, 9) == 0) ? $urandom_range(5, 10)
                                                : $urandom_range(1, 4));
      end else if (r < 68) transmit(15);
      else if (r < 85) backoff_wait();
      else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(bcb_pkg::op_e'($urandom_range(0, 3)), 8'($urandom), rbit(),
                    rbit(), rbit(), 8'($urandom));
        end
      end
    end
  endtask

  // Overfill the store: extra data bytes are dropped and the last mark still
  // closes the packet. The send then runs a few bytes, including a reload
  // from the store, before a collision cuts it short.
  task automatic full_store_pass();
    release_bus();
    drain();
    set_reg(bcb_pkg::CFG_CARRIER, 8'd5);
    set_reg(bcb_pkg::CFG_COLLISION, 8'd2);
    set_reg(bcb_pkg::CFG_BACKOFF, 8'd1);
    settle_idle();
    load_packet(130);
    send_try(1'b1, 8'd0);
    repeat (25) bit_tick(rbit(), 1'b0);
    bit_tick(rbit(), 1'b1);
    settle_idle();
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    operation_i      = '0;
    tx_byte_i        = '0;
    last_byte_i      = 1'b0;
    rx_level_i       = 1'b1;
    collision_seen_i = 1'b0;
    prio_delay_i     = '0;
    out_stall_i      = 1'b0;
    items_sent       = 0;
    quiet_cycles     = 0;
    gap_style        = 0;
    stall_style      = 0;
    hold_requests    = 0;
    hold_served      = 0;
    stall_left       = 0;
    sb = new();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner cases at reset register values, no idling
    directed_checks();
    settle_idle();

    gap_style   = 1;
    stall_style = 1;
    run_phase(bcb_pkg::CARRIER_RST, bcb_pkg::COLLISION_RST, bcb_pkg::BACKOFF_RST,
              25, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 25, 1'b0);          // phases end on first tick
    run_phase(8'd255, 8'd255, 8'd255, 20, 1'b0);
    full_store_pass();
    run_phase(8'($urandom_range(0, 40)), 8'd1, 8'd1, 25, 1'b1);
    run_phase(8'($urandom_range(0, 30)), 8'($urandom_range(1, 20)),
              8'($urandom_range(1, 30)), 25, 1'b0);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 30)), 25, 1'b0);

    release_bus();
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.errors++;
    end

    $display("Run: %0d items, %0d results checked, %0d mismatches", items_sent,
             sb.n_checked, sb.errors);
    $display("Bus events: %0d bytes received, %0d framing errors, %0d sends done,",
             sb.n_rx, sb.n_ferr, sb.n_done);
    $display("  %0d collisions", sb.n_coll);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
